[hdl/tpwm_pkg.sv]
// ----------------------------------------------------------------------------
// tpwm_pkg
// Shared types, register indexes and helpers for the three-phase triangle
// carrier PWM core and its serial arithmetic units.
// ----------------------------------------------------------------------------
`default_nettype none

package tpwm_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_CARRIER_RATE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUS_VOLTAGE  = 2'd1;

    // field widths fixed by the interface
    localparam int RATE_W = 24;
    localparam int BUS_W  = 16;
    localparam int DUTY_W = 17;
    localparam int LINE_W = 17;

    // result tdata: 3 gates, 3 phase voltages, 3 line voltages, byte padded
    localparam int OUT_FIELDS_W = 3 + 3 * BUS_W + 3 * LINE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // full-scale duty (100 percent)
    localparam logic [DUTY_W-1:0] DUTY_FULL = 17'h10000;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // clamp a duty to full scale
    function automatic logic [DUTY_W-1:0] sat_duty(input logic [DUTY_W-1:0] d);
        logic [DUTY_W-1:0] r;
        r = (d > DUTY_FULL) ? DUTY_FULL : d;
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/three_phase_triangle_pwm_core.sv]
// ----------------------------------------------------------------------------
// three_phase_triangle_pwm_core
// Three-phase PWM against a symmetric triangle carrier with a wrapping
// phase accumulator, gate compare, phase and line voltages.
// ----------------------------------------------------------------------------
// One item at a time. For an item with a nonzero interval and carrier rate,
// the phase advance interval*rate comes out of a bit-serial multiplier, one
// interval bit a cycle, and the substep rounding loss comes out of a
// bit-serial remainder divider, one product bit a cycle. An item with a zero
// interval or zero rate skips both units and goes straight to the finish
// state. A new item can be taken while the previous result still waits on
// the m_ side in the output register.
// Configuration writes are always ready and should only be issued while idle.
`default_nettype none

module three_phase_triangle_pwm_core #(
    parameter int PHASE_BITS          = 24,
    parameter int SUBSTEPS_PER_PERIOD = 8,
    parameter int INTERVAL_BITS       = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // configuration
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [tpwm_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [tpwm_pkg::CFG_DATA_W-1:0]        cfg_data,
    // input items
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // duty_a[16:0], duty_b[33:17], duty_c[50:34], interval[50+INTERVAL_BITS:51]
    input  wire logic [((51+INTERVAL_BITS+7)/8)*8-1:0]  s_tdata,
    // results
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // gate_a[0], gate_b[1], gate_c[2], volt_a[18:3], volt_b[34:19],
    // volt_c[50:35], line_ab[67:51], line_bc[84:68], line_ca[101:85]
    output logic [tpwm_pkg::OUT_TDATA_W-1:0]            m_tdata
);

    localparam int DW    = tpwm_pkg::DUTY_W;
    localparam int BW    = tpwm_pkg::BUS_W;
    localparam int LW    = tpwm_pkg::LINE_W;
    localparam int RW    = tpwm_pkg::RATE_W;
    localparam int ADV_W = INTERVAL_BITS + RW;
    localparam int SCL_W = ADV_W + 7;
    localparam int STP_W = SCL_W - PHASE_BITS;
    localparam int CMP_W = DW + PHASE_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [RW-1:0]           rate_reg;
    logic [BW-1:0]           bus_reg;
    logic [PHASE_BITS-1:0]   phase_reg, phase_next;
    logic [DW-1:0]           duty_a_reg, duty_b_reg, duty_c_reg;
    logic                    zero_reg;
    logic [ADV_W-1:0]        adv_reg;
    logic [STP_W-1:0]        steps_reg;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [tpwm_pkg::OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                    in_xfer;
    logic [INTERVAL_BITS-1:0] ival;
    logic                    in_zero;
    logic                    out_free;
    logic                    mul_start, div_start;
    logic [ADV_W-1:0]        adv;
    logic [STP_W-1:0]        rem;
    tpwm_pkg::unit_stat_t    mul_stat, div_stat;
    logic [SCL_W-1:0]        scaled;
    logic [STP_W-1:0]        steps_raw, steps;
    logic [PHASE_BITS:0]     tri_val;
    logic [CMP_W-1:0]        tri_cmp;
    logic                    ga, gb, gc;
    logic [BW-1:0]           va, vb, vc;
    logic [LW-1:0]           lab, lbc, lca;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign ival      = s_tdata[51 +: INTERVAL_BITS];
    assign in_zero   = (rate_reg == '0) || (ival == '0);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign mul_start = in_xfer && !in_zero;
    assign div_start = (state_reg == ST_MUL) && mul_stat.done;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= '0;
            bus_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                tpwm_pkg::CFG_CARRIER_RATE: rate_reg <= cfg_data[RW-1:0];
                tpwm_pkg::CFG_BUS_VOLTAGE:  bus_reg  <= cfg_data[BW-1:0];
                default: ;
            endcase
        end
    end

    // phase advance interval * rate
    tpwm_mul #(
        .A_W (INTERVAL_BITS),
        .B_W (RW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (ival),
        .op_b    (rate_reg),
        .product (adv),
        .stat    (mul_stat)
    );

    // substep count: ceil(advance * substeps / period), at least one
    always_comb begin
        scaled    = SCL_W'(adv) * SCL_W'(SUBSTEPS_PER_PERIOD)
                  + SCL_W'((64'd1 << PHASE_BITS) - 64'd1);
        steps_raw = scaled[SCL_W-1:PHASE_BITS];
        steps     = (steps_raw == '0) ? STP_W'(1) : steps_raw;
    end

    // rounding loss: advance mod steps
    tpwm_rem #(
        .DVD_W (ADV_W),
        .DVS_W (STP_W)
    ) u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (adv),
        .divisor   (steps),
        .remainder (rem),
        .stat      (div_stat)
    );

    // triangle carrier, gate compare, phase and line voltages at the current phase
    always_comb begin
        tri_val = phase_reg[PHASE_BITS-1]
                ? ((PHASE_BITS+1)'(0) - {phase_reg, 1'b0})
                : {phase_reg, 1'b0};
        tri_cmp = {tri_val, 16'd0};
        ga  = !zero_reg && ({duty_a_reg, {PHASE_BITS{1'b0}}} > tri_cmp);
        gb  = !zero_reg && ({duty_b_reg, {PHASE_BITS{1'b0}}} > tri_cmp);
        gc  = !zero_reg && ({duty_c_reg, {PHASE_BITS{1'b0}}} > tri_cmp);
        va  = ga ? bus_reg : '0;
        vb  = gb ? bus_reg : '0;
        vc  = gc ? bus_reg : '0;
        lab = {1'b0, va} - {1'b0, vb};
        lbc = {1'b0, vb} - {1'b0, vc};
        lca = {1'b0, vc} - {1'b0, va};
    end

    // sequencer and result register
    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = in_zero ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_stat.done) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    phase_next = phase_reg + adv_reg[PHASE_BITS-1:0]
                               - PHASE_BITS'(rem);
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = tpwm_pkg::OUT_TDATA_W'({lca, lbc, lab, vc, vb, va,
                                                             gc, gb, ga});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            phase_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // item payload
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        if (in_xfer) begin
            duty_a_reg <= tpwm_pkg::sat_duty(s_tdata[16:0]);
            duty_b_reg <= tpwm_pkg::sat_duty(s_tdata[33:17]);
            duty_c_reg <= tpwm_pkg::sat_duty(s_tdata[50:34]);
            zero_reg   <= in_zero;
        end
        if (div_start) begin
            adv_reg   <= adv;
            steps_reg <= steps;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // multiplier finishes only while the sequencer waits on it
    a_mul_done_in_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_stat.done |-> state_reg == ST_MUL)
        else $error("multiplier done outside multiply state");

    // divider finishes only while the sequencer waits on it
    a_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider done outside divide state");

    // rounding loss is always below the substep count
    a_rem_below_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> rem < steps_reg)
        else $error("remainder not below substep count");

    // carrier phase moves only when a remainder comes out
    a_phase_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !div_stat.done |=> phase_reg == $past(phase_reg))
        else $error("carrier phase changed without an advance");

    // a result is loaded only from the finish state
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside finish state");
`endif

endmodule

`default_nettype wire

[hdl/tpwm_mul.sv]
// ----------------------------------------------------------------------------
// tpwm_mul
// Shift-and-add multiplier: one multiplier bit per cycle, so only an
// operand-wide adder sits between registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tpwm_mul #(
    parameter int A_W = 16,
    parameter int B_W = 24
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [A_W-1:0]       op_a,
    input  wire logic [B_W-1:0]       op_b,
    output logic [A_W+B_W-1:0]        product,
    output tpwm_pkg::unit_stat_t      stat
);

    localparam int CNT_W = $clog2(A_W + 1);

    logic [A_W+B_W-1:0] prod_reg, prod_next;
    logic [B_W-1:0]     mcand_reg, mcand_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [B_W:0]       sum;

    // one partial product per cycle, shifted right into the low half
    always_comb begin
        sum = {1'b0, prod_reg[A_W+B_W-1:A_W]}
            + (prod_reg[0] ? {1'b0, mcand_reg} : {(B_W+1){1'b0}});
        prod_next  = prod_reg;
        mcand_next = mcand_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            prod_next  = {{B_W{1'b0}}, op_a};
            mcand_next = op_b;
            cnt_next   = CNT_W'(A_W);
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            prod_next = {sum, prod_reg[A_W-1:1]};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        prod_reg  <= prod_next;
        mcand_reg <= mcand_next;
    end

    assign product   = prod_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

[hdl/tpwm_rem.sv]
// ----------------------------------------------------------------------------
// tpwm_rem
// Restoring divider that keeps only the remainder: one dividend bit per
// cycle, one compare and subtract per step.
// ----------------------------------------------------------------------------
`default_nettype none

module tpwm_rem #(
    parameter int DVD_W = 40,
    parameter int DVS_W = 23
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [DVD_W-1:0]     dividend,
    input  wire logic [DVS_W-1:0]     divisor,
    output logic [DVS_W-1:0]          remainder,
    output tpwm_pkg::unit_stat_t      stat
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;

    // shift in the next dividend bit, subtract when the divisor fits
    always_comb begin
        trial     = {rem_reg, dvd_reg[DVD_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            rem_next = (trial >= {1'b0, dvs_reg}) ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire
